/* hdl/serial_dmx_frame_parser_defines.svh */
// assertion macros for the host-link frame parser
`ifndef SERIAL_DMX_FRAME_PARSER_DEFINES_SVH
`define SERIAL_DMX_FRAME_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SDMX_ASSERT_NOW(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sdmx assertion failed");
// next-cycle implication
`define SDMX_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sdmx assertion failed");
`else
`define SDMX_ASSERT_NOW(name, clk, rst_n, ante, cons)
`define SDMX_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

/* hdl/sdmx_pkg.sv */
// types and constants shared by the frame parser modules
`timescale 1ns / 1ps

package sdmx_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] CFG_START  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_END    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PLIMIT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FLIMIT = 3'd3;

	localparam int Q_PTR_W = 2;
	localparam int Q_DEPTH = 2 ** Q_PTR_W;
	localparam int Q_CNT_W = Q_PTR_W + 1;

	localparam logic [10:0] TOTAL_MAX = 11'h7ff;

	typedef enum logic [1:0] {
		KIND_PAYLOAD  = 2'd0,
		KIND_DONE     = 2'd1,
		KIND_BAD_SIZE = 2'd2,
		KIND_OVERRUN  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_LABEL    = 3'd1,
		PH_SIZE_LO  = 3'd2,
		PH_SIZE_HI  = 3'd3,
		PH_DATA     = 3'd4,
		PH_WAIT_END = 3'd5
	} phase_t;

	typedef struct packed {
		logic [7:0]  start_byte;
		logic [7:0]  end_byte;
		logic [9:0]  payload_limit;
		logic [10:0] frame_limit;
	} cfg_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  label;
		logic [9:0]  length;
		logic [9:0]  index;
		logic [7:0]  value;
	} event_t;

	typedef struct packed {
		logic push;
		logic idle;
	} front_stat_t;

	typedef struct packed {
		logic               full;
		logic               empty;
		logic [Q_CNT_W-1:0] count;
	} q_stat_t;

endpackage

/* hdl/serial_dmx_frame_parser.sv */
// top level of the host-link frame parser
//
// Input stream s_*: one rx_byte per beat in s_tdata[7:0]. Output stream m_*:
// one result per beat, kind in m_tuser, label/length/index/value in m_tdata.
// Only payload bytes, frame ends and dropped frames give results; other
// bytes (start, label, size, filler) are absorbed.
// Configuration channel cfg_*: register index and data, always ready;
// index 0 start byte, 1 end byte, 2 payload limit, 3 frame limit, others
// are ignored. Write only while the block is idle.
// Throughput: one byte per cycle while s_tready is high. A result passes
// from the front state machine into the result queue when its byte is
// taken, and from there into the output register that drives m_tvalid.
// When the receiver stalls, results collect in the four-entry queue and
// s_tready falls once it is full; a byte that gives no result is still held
// back at that point. Reset returns the parser to waiting for a start byte,
// empties the queue and restores default register values.
`timescale 1ns / 1ps
`include "serial_dmx_frame_parser_defines.svh"

module serial_dmx_frame_parser import sdmx_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [7:0] rx_byte
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [39:0]           m_tdata,   // [7:0] frame_label, [17:8] frame_length,
	                                         // [27:18] payload_index, [35:28] payload_value
	output logic [1:0]            m_tuser,   // [1:0] event_kind
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t        cfg_q;
	logic        accept;
	event_t      front_ev;
	front_stat_t front_stat;
	event_t      q_data;
	q_stat_t     q_stat;
	logic        q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte    <= 8'd126;
			cfg_q.end_byte      <= 8'd231;
			cfg_q.payload_limit <= 10'd600;
			cfg_q.frame_limit   <= 11'd605;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_START:  cfg_q.start_byte    <= cfg_data[7:0];
				CFG_END:    cfg_q.end_byte      <= cfg_data[7:0];
				CFG_PLIMIT: cfg_q.payload_limit <= cfg_data[9:0];
				CFG_FLIMIT: cfg_q.frame_limit   <= cfg_data;
				default:    cfg_q               <= cfg_q;
			endcase
		end
	end

	assign s_tready = !q_stat.full;
	assign accept   = s_tvalid && s_tready;

	sdmx_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.accept  (accept),
		.rx_byte (s_tdata),
		.ev      (front_ev),
		.stat    (front_stat)
	);

	sdmx_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (front_stat.push),
		.push_data (front_ev),
		.pop       (q_pop),
		.pop_data  (q_data),
		.stat      (q_stat)
	);

	sdmx_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (!q_stat.empty),
		.q_data   (q_data),
		.pop      (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// every frame-ending result leaves the parser waiting for a start byte
	`SDMX_ASSERT_NEXT(a_end_to_idle, clk, arst_n, front_stat.push && front_ev.kind != KIND_PAYLOAD, front_stat.idle)
	`SDMX_ASSERT_NOW(a_queue_bound, clk, arst_n, 1'b1, q_stat.count <= Q_CNT_W'(Q_DEPTH))
	`SDMX_ASSERT_NOW(a_idx_zero, clk, arst_n, m_tvalid && m_tuser != KIND_PAYLOAD, m_tdata[35:18] == 18'd0)
	`SDMX_ASSERT_NOW(a_len_zero, clk, arst_n, m_tvalid && m_tuser != KIND_DONE, m_tdata[17:8] == 10'd0)

endmodule

/* hdl/sdmx_front.sv */
// front end: frame state machine that classifies each byte into a result
`timescale 1ns / 1ps

module sdmx_front import sdmx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        accept,
	input  logic [7:0]  rx_byte,
	output event_t      ev,
	output front_stat_t stat
);

	phase_t      phase_q, phase_d;
	logic [7:0]  label_q, label_d;
	logic [15:0] size_q, size_d;
	logic [9:0]  count_q, count_d;
	logic [10:0] total_q, total_d;
	logic [10:0] total_inc;
	logic [15:0] new_size;
	logic [9:0]  count_nxt;
	logic        push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			label_q <= '0;
			size_q  <= '0;
			count_q <= '0;
			total_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			label_q <= label_d;
			size_q  <= size_d;
			count_q <= count_d;
			total_q <= total_d;
		end
	end

	always_comb begin
		total_inc = (phase_q != PH_IDLE && total_q != TOTAL_MAX) ? total_q + 11'd1 : total_q;
		new_size  = {rx_byte, size_q[7:0]};
		count_nxt = count_q + 10'd1;
		phase_d   = phase_q;
		label_d   = label_q;
		size_d    = size_q;
		count_d   = count_q;
		total_d   = total_inc;
		push      = 1'b0;
		ev        = '{kind: KIND_PAYLOAD, label: label_q, length: '0, index: '0, value: '0};
		unique case (phase_q)
			PH_LABEL: begin
				label_d = rx_byte;
				phase_d = PH_SIZE_LO;
			end
			PH_SIZE_LO: begin
				size_d  = {size_q[15:8], rx_byte};
				phase_d = PH_SIZE_HI;
			end
			PH_SIZE_HI: begin
				size_d = new_size;
				if (new_size == 16'd0) begin
					phase_d = PH_WAIT_END;
				end else if (new_size > {6'd0, cfg.payload_limit}) begin
					phase_d = PH_IDLE;
					total_d = '0;
					count_d = '0;
					push    = 1'b1;
					ev.kind = KIND_BAD_SIZE;
				end else begin
					phase_d = PH_DATA;
				end
			end
			PH_DATA: begin
				push     = 1'b1;
				ev.index = count_q;
				ev.value = rx_byte;
				count_d  = count_nxt;
				if (count_nxt >= cfg.payload_limit || {6'd0, count_nxt} >= size_q) begin
					phase_d = PH_WAIT_END;
				end
			end
			PH_WAIT_END: begin
				if (rx_byte == cfg.end_byte) begin
					phase_d   = PH_IDLE;
					push      = 1'b1;
					ev.kind   = KIND_DONE;
					ev.length = count_q;
				end else if (total_inc >= cfg.frame_limit) begin
					// gave up waiting for the closing byte
					phase_d = PH_IDLE;
					total_d = '0;
					count_d = '0;
					push    = 1'b1;
					ev.kind = KIND_OVERRUN;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				if (rx_byte == cfg.start_byte) begin
					phase_d = PH_LABEL;
					total_d = 11'd1;
					count_d = '0;
				end
			end
		endcase
	end

	assign stat.push = accept && push;
	assign stat.idle = (phase_q == PH_IDLE);

endmodule

/* hdl/sdmx_queue.sv */
// small result queue between the front end and the output stage
`timescale 1ns / 1ps

module sdmx_queue import sdmx_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  event_t  push_data,
	input  logic    pop,
	output event_t  pop_data,
	output q_stat_t stat
);

	event_t             mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + Q_CNT_W'(1);
				2'b01:   count_q <= count_q - Q_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign pop_data   = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == Q_CNT_W'(Q_DEPTH));
	assign stat.empty = (count_q == '0);
	assign stat.count = count_q;

endmodule

/* hdl/sdmx_back.sv */
// back end: output register that drives the result stream
`timescale 1ns / 1ps

module sdmx_back import sdmx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  event_t      q_data,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,
	output logic [1:0]  m_tuser
);

	event_t out_q;
	logic   valid_q;

	// refill whenever the register is empty or its beat leaves this cycle
	assign pop = q_valid && (!valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || m_tready) begin
			valid_q <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= q_data;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {4'd0, out_q.value, out_q.index, out_q.length, out_q.label};
	assign m_tuser  = out_q.kind;

endmodule

/* tb/tb_serial_dmx_frame_parser.sv */
// self-checking testbench for the host-link frame parser
`timescale 1ns / 1ps

module tb_serial_dmx_frame_parser;
	import sdmx_pkg::*;

	localparam int CYCLE_LIMIT = 400_000;

	// tracks the parser state byte by byte and holds the results still owed by the block
	class frame_scoreboard;
		cfg_t        regs;
		phase_t      phase;
		logic [7:0]  label;
		logic [15:0] size;
		logic [9:0]  count;
		logic [10:0] total;
		event_t      owed[$];
		int          n_bytes;
		int          n_bad;
		int          n_kind[4];

		function new();
			regs.start_byte    = 8'd126;
			regs.end_byte      = 8'd231;
			regs.payload_limit = 10'd600;
			regs.frame_limit   = 11'd605;
			phase = PH_IDLE;
			label = '0;
			size  = '0;
			count = '0;
			total = '0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_START:  regs.start_byte    = data[7:0];
				CFG_END:    regs.end_byte      = data[7:0];
				CFG_PLIMIT: regs.payload_limit = data[9:0];
				CFG_FLIMIT: regs.frame_limit   = data[10:0];
				default: ;
			endcase
		endfunction

		function void note_byte(logic [7:0] b);
			event_t ev;
			bit     fire;
			ev = '0;
			fire = 0;
			n_bytes++;
			if (phase != PH_IDLE && total != TOTAL_MAX)
				total++;
			case (phase)
				PH_LABEL: begin
					label = b;
					phase = PH_SIZE_LO;
				end
				PH_SIZE_LO: begin
					size[7:0] = b;
					phase = PH_SIZE_HI;
				end
				PH_SIZE_HI: begin
					size[15:8] = b;
					if (size == 0) begin
						phase = PH_WAIT_END;
					end else if (size > regs.payload_limit) begin
						phase = PH_IDLE;
						total = '0;
						count = '0;
						ev.kind = KIND_BAD_SIZE;
						fire = 1;
					end else begin
						phase = PH_DATA;
					end
				end
				PH_DATA: begin
					ev.kind = KIND_PAYLOAD;
					ev.index = count;
					ev.value = b;
					fire = 1;
					count++;
					if (count >= regs.payload_limit || count >= size)
						phase = PH_WAIT_END;
				end
				PH_WAIT_END: begin
					// end byte wins over the overrun check
					if (b == regs.end_byte) begin
						phase = PH_IDLE;
						ev.kind = KIND_DONE;
						ev.length = count;
						fire = 1;
					end else if (total >= regs.frame_limit) begin
						phase = PH_IDLE;
						total = '0;
						count = '0;
						ev.kind = KIND_OVERRUN;
						fire = 1;
					end
				end
				default: begin
					if (b == regs.start_byte) begin
						phase = PH_LABEL;
						total = 11'd1;
						count = '0;
					end
				end
			endcase
			if (fire) begin
				ev.label = label;
				owed.push_back(ev);
			end
		endfunction

		function void check_event(logic [1:0] kind, logic [39:0] data);
			event_t got;
			event_t want;
			got.kind   = kind_t'(kind);
			got.label  = data[7:0];
			got.length = data[17:8];
			got.index  = data[27:18];
			got.value  = data[35:28];
			if (owed.size() == 0) begin
				n_bad++;
				if (n_bad <= 10)
					$display("unexpected result: kind %0d label %h len %0d idx %0d val %h",
						got.kind, got.label, got.length, got.index, got.value);
				return;
			end
			want = owed.pop_front();
			n_kind[want.kind]++;
			if (got.kind != want.kind || got.label != want.label || got.length != want.length ||
					got.index != want.index || got.value != want.value) begin
				n_bad++;
				if (n_bad <= 10)
					$display({"mismatch: expected kind %0d label %h len %0d idx %0d val %h, ",
						"got kind %0d label %h len %0d idx %0d val %h"},
						want.kind, want.label, want.length, want.index, want.value,
						got.kind, got.label, got.length, got.index, got.value);
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [39:0]           m_tdata;
	logic [1:0]            m_tuser;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	frame_scoreboard sb = new();
	logic [7:0]      tx_bytes[$];
	int              rx_hold = 0;
	bit              rx_burst = 0;
	bit              tx_burst = 0;
	int              cycle_count = 0;

	serial_dmx_frame_parser i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				sb.owed.size());
			$display("** serial_dmx_frame_parser: FAILED **");
			$finish;
		end
	end

	// result side: random stalls, bursts of full readiness, and one long hold-off on request
	initial begin
		int stall;
		forever begin
			stall = rx_hold;
			rx_hold = 0;
			if (stall == 0) begin
				if ($urandom_range(0, 31) == 0)
					rx_burst = !rx_burst;
				stall = rx_burst ? 0 : $urandom_range(0, 10);
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (m_tvalid !== 1'b1) @(posedge clk);
			sb.check_event(m_tuser, m_tdata);
		end
	end

	function automatic logic [7:0] other_byte();
		logic [7:0] b;
		do b = 8'($urandom); while (b == sb.regs.end_byte);
		return b;
	endfunction

	task automatic program_regs(logic [7:0] st, logic [7:0] en, logic [9:0] pl,
			logic [10:0] fl);
		logic [CFG_IDX_W-1:0]  idx[5];
		logic [CFG_DATA_W-1:0] val[5];
		idx = '{CFG_START, CFG_END, CFG_PLIMIT, CFG_FLIMIT,
			3'(CFG_FLIMIT + 3'($urandom_range(1, 4)))};
		// upper bits of the narrow registers carry junk that must be dropped
		val = '{{3'($urandom), st}, {3'($urandom), en}, {1'($urandom), pl}, fl,
			11'($urandom)};
		for (int i = 0; i < 5; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			@(posedge clk);
			while (cfg_ready !== 1'b1) @(posedge clk);
			sb.write_reg(idx[i], val[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	// appends frames (mostly well formed, some broken) and stray bytes until at least n bytes were added
	task automatic fill_random(int n);
		int          goal;
		int          pick;
		int          size;
		int          need;
		logic [15:0] dsize;
		logic [9:0]  plim;
		logic [10:0] flim;
		goal = tx_bytes.size() + n;
		plim = sb.regs.payload_limit;
		flim = sb.regs.frame_limit;
		while (tx_bytes.size() < goal) begin
			pick = $urandom_range(0, 99);
			if (pick >= 80 && pick < 88 && flim > 64)
				pick = 0;
			if (pick >= 94) begin
				// frame cut off inside the header
				tx_bytes.push_back(sb.regs.start_byte);
				repeat ($urandom_range(1, 2)) tx_bytes.push_back(8'($urandom));
			end else if (pick >= 88) begin
				repeat ($urandom_range(1, 4)) tx_bytes.push_back(8'($urandom));
			end else begin
				if (pick >= 70 && pick < 80)
					size = ($urandom_range(0, 2) == 0) ? $urandom_range(plim + 1, 65535)
						: plim + $urandom_range(1, 3);
				else if ((pick >= 60 && pick < 70) || plim == 0)
					size = 0;
				else if (plim <= 64 && $urandom_range(0, 7) == 0)
					size = $urandom_range(1, plim);
				else
					size = $urandom_range(1, (plim < 8) ? plim : 8);
				dsize = 16'(size);
				tx_bytes.push_back(sb.regs.start_byte);
				tx_bytes.push_back(8'($urandom));
				tx_bytes.push_back(dsize[7:0]);
				tx_bytes.push_back(dsize[15:8]);
				if (size <= plim) begin
					repeat (size) tx_bytes.push_back(8'($urandom));
					if (pick >= 80) begin
						// filler right up to the frame limit
						need = flim - 4 - size;
						if (need < 1)
							need = 1;
						repeat (need) tx_bytes.push_back(other_byte());
					end else begin
						repeat ($urandom_range(0, 2)) tx_bytes.push_back(other_byte());
						tx_bytes.push_back(sb.regs.end_byte);
					end
				end
			end
		end
	endtask

	// drives every queued byte; at beat pause_at waits for all owed results first
	task automatic send_bytes(int pause_at);
		int         gap;
		int         sent;
		logic [7:0] b;
		sent = 0;
		while (tx_bytes.size() != 0) begin
			if (sent == pause_at && sb.owed.size() != 0) begin
				s_tvalid <= 1'b0;
				while (sb.owed.size() != 0) @(posedge clk);
			end
			if ($urandom_range(0, 31) == 0)
				tx_burst = !tx_burst;
			gap = tx_burst ? 0 : $urandom_range(0, 10);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			b = tx_bytes.pop_front();
			s_tvalid <= 1'b1;
			s_tdata  <= b;
			@(posedge clk);
			while (s_tready !== 1'b1) @(posedge clk);
			sb.note_byte(b);
			sent++;
		end
		s_tvalid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (sb.owed.size() != 0) @(posedge clk);
		// bytes with no result may still sit in the front end
		repeat (6) @(posedge clk);
	endtask

	initial begin
		logic [7:0] st;
		logic [7:0] en;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: noise, a short frame with a start byte as filler, empty and oversized frames
		st = sb.regs.start_byte;
		en = sb.regs.end_byte;
		tx_bytes = {8'h00, 8'hff, st, 8'hff, 8'h02, 8'h00, 8'h00, 8'hff, st, en,
			st, 8'h00, 8'h00, 8'h00, en,
			st, 8'h5a, 8'h59, 8'h02,
			st, 8'h81, 8'hff, 8'hff};
		send_bytes(-1);
		wait_idle();

		// small limits, long receiver hold-off and a full pause on the sender side
		st = 8'($urandom);
		en = st ^ 8'($urandom_range(1, 255));
		program_regs(st, en, 10'd12, 11'd24);
		fill_random(300);
		rx_hold = 300;
		send_bytes(150);
		wait_idle();

		// widest limits with one long payload and a size just above the limit
		program_regs(8'h00, 8'hff, 10'd1023, 11'd2047);
		tx_bytes.push_back(8'h00);
		tx_bytes.push_back(8'($urandom));
		tx_bytes.push_back(8'h00);
		tx_bytes.push_back(8'h01);
		repeat (256) tx_bytes.push_back(8'($urandom));
		tx_bytes.push_back(8'hff);
		tx_bytes = {tx_bytes, 8'h00, 8'($urandom), 8'h00, 8'h04};
		fill_random(100);
		send_bytes(-1);
		wait_idle();

		// narrowest legal limits
		program_regs(8'hff, 8'h00, 10'd1, 11'd5);
		fill_random(150);
		send_bytes(-1);
		wait_idle();

		// limits below the legal range and start byte equal to end byte
		st = 8'($urandom);
		program_regs(st, st, 10'd0, 11'd1);
		fill_random(100);
		send_bytes(-1);
		wait_idle();

		program_regs(8'($urandom), 8'($urandom), 10'($urandom_range(1, 40)),
			11'($urandom_range(5, 60)));
		fill_random(150);
		send_bytes(-1);
		wait_idle();

		repeat (10) @(posedge clk);
		$display({"%0d bytes over six register settings: ",
			"%0d payload, %0d done, %0d bad size, %0d overrun"},
			sb.n_bytes, sb.n_kind[KIND_PAYLOAD], sb.n_kind[KIND_DONE],
			sb.n_kind[KIND_BAD_SIZE], sb.n_kind[KIND_OVERRUN]);
		$display("%0d result mismatches, %0d results still owed", sb.n_bad, sb.owed.size());
		if (sb.n_bad == 0 && sb.owed.size() == 0)
			$display("** serial_dmx_frame_parser: PASSED **");
		else
			$display("** serial_dmx_frame_parser: FAILED **");
		$finish;
	end

endmodule
